[rtl/core/mbc_pkg.sv]
`default_nettype none

package mbc_pkg;

    localparam int MAX_WIDTH_DEF   = 64;
    localparam int MAX_HEIGHT_DEF  = 64;
    localparam int RANDOM_BITS_DEF = 16;

    // width of maze dimension registers and of the in-use dimension math
    localparam int REG_W  = 7;
    localparam int DIM_W  = 9;
    localparam int RND_W  = 16;
    localparam int COORD_OUT_W = 6;

    typedef enum logic [0:0] {
        REG_MAZE_WIDTH  = 1'b0,
        REG_MAZE_HEIGHT = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_UP    = 2'd3
    } dir_t;

    typedef enum logic [0:0] {
        KIND_START = 1'b0,
        KIND_STEP  = 1'b1
    } kind_t;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_CLEAR = 10'b00_0000_0010,
        S_INIT  = 10'b00_0000_0100,
        S_LOAD  = 10'b00_0000_1000,
        S_TOP   = 10'b00_0001_0000,
        S_PROBE = 10'b00_0010_0000,
        S_PICK  = 10'b00_0100_0000,
        S_MOD   = 10'b00_1000_0000,
        S_CARVE = 10'b01_0000_0000,
        S_EMIT  = 10'b10_0000_0000
    } state_t;

    // k-th set bit of the free mask, scanning right, left, down, up
    function automatic dir_t pick_dir(input logic [3:0] mask, input logic [1:0] k);
        logic [2:0] seen;
        dir_t       d;
        seen = 3'd0;
        d    = DIR_RIGHT;
        for (int i = 0; i < 4; i++) begin
            if (mask[i]) begin
                if (seen == {1'b0, k}) begin
                    d = dir_t'(2'(i));
                end
                seen = seen + 3'd1;
            end
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[rtl/core/maze_backtracker_carver_top.sv]
// start beat: the visited map ram is cleared, all 2^(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) entries,
//   one entry per cycle, then cell (0,0) is marked visited and pushed before the beat is emitted
// step beat: each stack cell examined needs a stack read and 4 visited reads; dead ends pop,
//   else a serial remainder unit works through min(RANDOM_BITS,16) random bits and a wall is carved
// one beat in flight at a time; s_tready is high only while the sequencer is idle
// reset: sequencer idle, stack empty, maze_width and maze_height 64; visited map cleared by start
`default_nettype none

module maze_backtracker_carver_top #(
    parameter int MAX_WIDTH   = mbc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = mbc_pkg::MAX_HEIGHT_DEF,
    parameter int RANDOM_BITS = mbc_pkg::RANDOM_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,

    input  wire logic                      cfg_wr_en,
    input  wire logic [0:0]                cfg_wr_index,
    input  wire logic [mbc_pkg::REG_W-1:0] cfg_wr_data,

    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [15:0]               s_tdata,   // random_value[15:0]
    input  wire logic [0:0]                s_tuser,   // kind[0]

    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic      [15:0]               m_tdata,   // wall_x[5:0] wall_y[11:6] wall_dir[13:12] pad
    output logic      [1:0]                m_tuser    // carved[0], finished[1]
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int CW    = XW + YW;
    localparam int VDEP  = 1 << CW;
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int SAW   = $clog2(CELLS);
    localparam int DPW   = $clog2(CELLS + 1);
    localparam int RB    = (RANDOM_BITS < mbc_pkg::RND_W) ? RANDOM_BITS : mbc_pkg::RND_W;
    localparam int BIW   = $clog2(RB);
    localparam int DW    = mbc_pkg::DIM_W;
    localparam int OW    = mbc_pkg::COORD_OUT_W;

    mbc_pkg::state_t state_reg, state_next;

    logic [mbc_pkg::REG_W-1:0] maze_width_reg, maze_width_next;
    logic [mbc_pkg::REG_W-1:0] maze_height_reg, maze_height_next;
    logic [DPW-1:0]   depth_reg, depth_next;
    logic [CW-1:0]    clr_addr_reg, clr_addr_next;
    logic [XW-1:0]    cur_x_reg, cur_x_next;
    logic [YW-1:0]    cur_y_reg, cur_y_next;
    logic [2:0]       pd_reg, pd_next;
    logic [3:0]       mask_reg, mask_next;
    logic [2:0]       count_reg, count_next;
    logic [1:0]       rem_reg, rem_next;
    logic [BIW-1:0]   bit_idx_reg, bit_idx_next;
    logic [RB-1:0]    rnd_reg, rnd_next;
    logic [OW-1:0]    res_x_reg, res_x_next;
    logic [OW-1:0]    res_y_reg, res_y_next;
    logic [1:0]       res_dir_reg, res_dir_next;
    logic             res_carved_reg, res_carved_next;
    logic             res_fin_reg, res_fin_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [15:0]      m_tdata_reg, m_tdata_next;
    logic [1:0]       m_tuser_reg, m_tuser_next;

    logic [DW-1:0]    used_w, used_h;
    logic [3:0]       in_b;
    logic [XW-1:0]    nx [4];
    logic [YW-1:0]    ny [4];
    logic [1:0]       cap_dir;
    mbc_pkg::dir_t    sel_dir;
    logic [2:0]       rem_t;

    logic             vis_we;
    logic [CW-1:0]    vis_waddr, vis_raddr;
    logic [0:0]       vis_wdata, vis_rdata;
    logic             stk_we;
    logic [SAW-1:0]   stk_waddr, stk_raddr;
    logic [CW-1:0]    stk_wdata, stk_rdata;

    mbc_ram #(.DATA_W(1), .DEPTH(VDEP)) u_visited (
        .aclk  (aclk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    mbc_ram #(.DATA_W(CW), .DEPTH(CELLS)) u_stack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign s_tready = (state_reg == mbc_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        if (maze_width_reg == '0) begin
            used_w = DW'(1);
        end else if (DW'(maze_width_reg) > DW'(MAX_WIDTH)) begin
            used_w = DW'(MAX_WIDTH);
        end else begin
            used_w = DW'(maze_width_reg);
        end
        if (maze_height_reg == '0) begin
            used_h = DW'(1);
        end else if (DW'(maze_height_reg) > DW'(MAX_HEIGHT)) begin
            used_h = DW'(MAX_HEIGHT);
        end else begin
            used_h = DW'(maze_height_reg);
        end
    end

    // neighbor coordinates and bounds of the cell under test
    always_comb begin
        in_b[0] = ((DW'(cur_x_reg) + DW'(1)) < used_w) && (DW'(cur_y_reg) < used_h);
        in_b[1] = (cur_x_reg != '0) && ((DW'(cur_x_reg) - DW'(1)) < used_w)
                  && (DW'(cur_y_reg) < used_h);
        in_b[2] = (DW'(cur_x_reg) < used_w) && ((DW'(cur_y_reg) + DW'(1)) < used_h);
        in_b[3] = (cur_y_reg != '0) && ((DW'(cur_y_reg) - DW'(1)) < used_h)
                  && (DW'(cur_x_reg) < used_w);
        nx[0] = cur_x_reg + XW'(1);
        ny[0] = cur_y_reg;
        nx[1] = cur_x_reg - XW'(1);
        ny[1] = cur_y_reg;
        nx[2] = cur_x_reg;
        ny[2] = cur_y_reg + YW'(1);
        nx[3] = cur_x_reg;
        ny[3] = cur_y_reg - YW'(1);
    end

    assign cap_dir = 2'(pd_reg - 3'd1);
    assign sel_dir = mbc_pkg::pick_dir(mask_reg, rem_reg);
    assign rem_t   = {rem_reg, rnd_reg[bit_idx_reg]};

    always_comb begin
        state_next       = state_reg;
        maze_width_next  = maze_width_reg;
        maze_height_next = maze_height_reg;
        depth_next       = depth_reg;
        clr_addr_next    = clr_addr_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        pd_next          = pd_reg;
        mask_next        = mask_reg;
        count_next       = count_reg;
        rem_next         = rem_reg;
        bit_idx_next     = bit_idx_reg;
        rnd_next         = rnd_reg;
        res_x_next       = res_x_reg;
        res_y_next       = res_y_reg;
        res_dir_next     = res_dir_reg;
        res_carved_next  = res_carved_reg;
        res_fin_next     = res_fin_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;

        vis_we    = 1'b0;
        vis_waddr = clr_addr_reg;
        vis_wdata = 1'b0;
        vis_raddr = {ny[pd_reg[1:0]], nx[pd_reg[1:0]]};
        stk_we    = 1'b0;
        stk_waddr = depth_reg[SAW-1:0];
        stk_wdata = {ny[sel_dir], nx[sel_dir]};
        stk_raddr = SAW'(depth_reg - DPW'(1));

        if (cfg_wr_en) begin
            case (cfg_wr_index)
                mbc_pkg::REG_MAZE_WIDTH:  maze_width_next  = cfg_wr_data;
                mbc_pkg::REG_MAZE_HEIGHT: maze_height_next = cfg_wr_data;
                default: ;
            endcase
        end

        case (state_reg)
            mbc_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    rnd_next        = s_tdata[RB-1:0];
                    res_x_next      = '0;
                    res_y_next      = '0;
                    res_dir_next    = '0;
                    res_carved_next = 1'b0;
                    res_fin_next    = 1'b0;
                    if (s_tuser == mbc_pkg::KIND_START) begin
                        clr_addr_next = '0;
                        state_next    = mbc_pkg::S_CLEAR;
                    end else begin
                        state_next = mbc_pkg::S_LOAD;
                    end
                end
            end
            mbc_pkg::S_CLEAR: begin
                vis_we        = 1'b1;
                clr_addr_next = clr_addr_reg + CW'(1);
                if (clr_addr_reg == '1) begin
                    state_next = mbc_pkg::S_INIT;
                end
            end
            mbc_pkg::S_INIT: begin
                vis_we     = 1'b1;
                vis_waddr  = '0;
                vis_wdata  = 1'b1;
                stk_we     = 1'b1;
                stk_waddr  = '0;
                stk_wdata  = '0;
                depth_next = DPW'(1);
                state_next = mbc_pkg::S_EMIT;
            end
            mbc_pkg::S_LOAD: begin
                if (depth_reg == '0) begin
                    res_fin_next = 1'b1;
                    state_next   = mbc_pkg::S_EMIT;
                end else begin
                    state_next = mbc_pkg::S_TOP;
                end
            end
            mbc_pkg::S_TOP: begin
                cur_x_next = stk_rdata[XW-1:0];
                cur_y_next = stk_rdata[CW-1:XW];
                pd_next    = '0;
                mask_next  = '0;
                state_next = mbc_pkg::S_PROBE;
            end
            mbc_pkg::S_PROBE: begin
                pd_next = pd_reg + 3'd1;
                if (pd_reg != '0) begin
                    mask_next[cap_dir] = in_b[cap_dir] & ~vis_rdata[0];
                end
                if (pd_reg == 3'd4) begin
                    state_next = mbc_pkg::S_PICK;
                end
            end
            mbc_pkg::S_PICK: begin
                count_next   = 3'($countones(mask_reg));
                rem_next     = '0;
                bit_idx_next = BIW'(RB - 1);
                if (mask_reg == '0) begin
                    depth_next = depth_reg - DPW'(1);
                    state_next = mbc_pkg::S_LOAD;
                end else begin
                    state_next = mbc_pkg::S_MOD;
                end
            end
            mbc_pkg::S_MOD: begin
                if (rem_t >= count_reg) begin
                    rem_next = 2'(rem_t - count_reg);
                end else begin
                    rem_next = rem_t[1:0];
                end
                bit_idx_next = bit_idx_reg - BIW'(1);
                if (bit_idx_reg == '0) begin
                    state_next = mbc_pkg::S_CARVE;
                end
            end
            mbc_pkg::S_CARVE: begin
                vis_we    = 1'b1;
                vis_waddr = {ny[sel_dir], nx[sel_dir]};
                vis_wdata = 1'b1;
                if (depth_reg < DPW'(CELLS)) begin
                    stk_we     = 1'b1;
                    depth_next = depth_reg + DPW'(1);
                end
                res_x_next      = OW'(cur_x_reg);
                res_y_next      = OW'(cur_y_reg);
                res_dir_next    = sel_dir;
                res_carved_next = 1'b1;
                state_next      = mbc_pkg::S_EMIT;
            end
            mbc_pkg::S_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, res_dir_reg, res_y_reg, res_x_reg};
                    m_tuser_next  = {res_fin_reg, res_carved_reg};
                    state_next    = mbc_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = mbc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= mbc_pkg::S_IDLE;
            maze_width_reg  <= mbc_pkg::REG_W'(64);
            maze_height_reg <= mbc_pkg::REG_W'(64);
            depth_reg       <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            maze_width_reg  <= maze_width_next;
            maze_height_reg <= maze_height_next;
            depth_reg       <= depth_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        clr_addr_reg   <= clr_addr_next;
        cur_x_reg      <= cur_x_next;
        cur_y_reg      <= cur_y_next;
        pd_reg         <= pd_next;
        mask_reg       <= mask_next;
        count_reg      <= count_next;
        rem_reg        <= rem_next;
        bit_idx_reg    <= bit_idx_next;
        rnd_reg        <= rnd_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        res_dir_reg    <= res_dir_next;
        res_carved_reg <= res_carved_next;
        res_fin_reg    <= res_fin_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DPW'(CELLS))
        else $error("stack depth beyond cell count");

    a_carved_not_finished: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("beat both carved and finished");

    a_rem_below_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mbc_pkg::S_MOD |-> rem_reg < count_reg)
        else $error("remainder not below candidate count");

    a_carve_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mbc_pkg::S_CARVE |=> depth_reg == DPW'($past(depth_reg) + DPW'(1)))
        else $error("carve did not push the new cell");
`endif

endmodule

`default_nettype wire

[rtl/core/mbc_ram.sv]
`default_nettype none

module mbc_ram #(
    parameter int DATA_W = 1,
    parameter int DEPTH  = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[test/tb_maze_backtracker_carver_top.sv]
`default_nettype none

module tb_maze_backtracker_carver_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mbc_pkg::*;

    localparam int GRID_W         = 64;
    localparam int GRID_H         = 64;
    localparam int CELLS          = GRID_W * GRID_H;
    localparam int ITEM_TARGET    = 1250;
    localparam int TAIL_ITEMS     = 100;
    localparam int HOLD_AFTER     = 150;
    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 50000;

    typedef struct {
        kind_t       kind;
        logic [15:0] rnd;
    } carve_cmd_t;

    typedef struct packed {
        logic [5:0] wall_x;
        logic [5:0] wall_y;
        dir_t       wall_dir;
        logic       carved;
        logic       finished;
    } wall_result_t;

    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 cfg_wr_en    = 1'b0;
    logic [0:0]           cfg_wr_index = REG_MAZE_WIDTH;
    logic [REG_W-1:0]     cfg_wr_data  = '0;
    logic                 s_tvalid     = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata      = '0;
    logic [0:0]           s_tuser      = KIND_START;
    logic                 m_tvalid;
    logic                 m_tready     = 1'b0;
    logic [15:0]          m_tdata;
    logic [1:0]           m_tuser;

    // mirror of the block state
    logic [REG_W-1:0]     width_reg  = 7'd64;
    logic [REG_W-1:0]     height_reg = 7'd64;
    bit                   visited [CELLS];
    int                   stack_x [CELLS];
    int                   stack_y [CELLS];
    int                   depth = 0;

    carve_cmd_t           carve_cmds [$];
    wall_result_t         wall_expect [$];
    carve_cmd_t           next_cmd;
    wall_result_t         want;

    int                   errors = 0;
    int                   items_made = 0;
    bit                   no_idle = 1'b0;
    int                   quiet_cycles = 0;

    int                   send_gap = 0;
    int                   send_stretch = 0;
    bit                   send_rough = 1'b0;
    int                   recv_stall = 0;
    int                   recv_stretch = 0;
    bit                   recv_rough = 1'b0;
    int                   hold_left = 0;
    bit                   hold_done = 1'b0;
    int                   results_taken = 0;

    maze_backtracker_carver_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic int dim_in_use(logic [REG_W-1:0] r, int lim);
        if (r == 0) return 1;
        if (int'(r) > lim) return lim;
        return int'(r);
    endfunction

    function automatic bit cell_free(int cx, int cy, int w, int h);
        if (cx < 0 || cy < 0 || cx >= w || cy >= h) return 1'b0;
        return !visited[cy * GRID_W + cx];
    endfunction

    function automatic void mark_and_push(int cx, int cy);
        visited[cy * GRID_W + cx] = 1'b1;
        if (depth < CELLS) begin
            stack_x[depth] = cx;
            stack_y[depth] = cy;
            depth++;
        end
    endfunction

    function automatic wall_result_t predict_wall(kind_t k, logic [15:0] rnd);
        wall_result_t r;
        int           w, h, cx, cy, cnt, nx, ny;
        dir_t         cand [4];
        dir_t         d;
        r = '0;
        w = dim_in_use(width_reg, GRID_W);
        h = dim_in_use(height_reg, GRID_H);
        if (k == KIND_START) begin
            foreach (visited[i]) visited[i] = 1'b0;
            depth = 0;
            mark_and_push(0, 0);
            return r;
        end
        while (depth > 0) begin
            cx  = stack_x[depth - 1];
            cy  = stack_y[depth - 1];
            cnt = 0;
            if (cell_free(cx + 1, cy, w, h)) begin
                cand[cnt] = DIR_RIGHT;
                cnt++;
            end
            if (cell_free(cx - 1, cy, w, h)) begin
                cand[cnt] = DIR_LEFT;
                cnt++;
            end
            if (cell_free(cx, cy + 1, w, h)) begin
                cand[cnt] = DIR_DOWN;
                cnt++;
            end
            if (cell_free(cx, cy - 1, w, h)) begin
                cand[cnt] = DIR_UP;
                cnt++;
            end
            if (cnt == 0) begin
                depth--;
            end else begin
                d  = cand[int'(rnd) % cnt];
                nx = cx;
                ny = cy;
                case (d)
                    DIR_RIGHT: nx = cx + 1;
                    DIR_LEFT:  nx = cx - 1;
                    DIR_DOWN:  ny = cy + 1;
                    default:   ny = cy - 1;
                endcase
                mark_and_push(nx, ny);
                r.wall_x   = cx[5:0];
                r.wall_y   = cy[5:0];
                r.wall_dir = d;
                r.carved   = 1'b1;
                return r;
            end
        end
        r.finished = 1'b1;
        return r;
    endfunction

    function automatic logic [15:0] pick_rnd();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 3));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic queue_cmd(kind_t k, logic [15:0] rnd);
        carve_cmd_t c;
        c.kind = k;
        c.rnd  = rnd;
        carve_cmds.insert(carve_cmds.size(), c);
        items_made++;
        if (items_made >= ITEM_TARGET - TAIL_ITEMS) no_idle = 1'b1;
    endtask

    task automatic settle();
        do @(negedge aclk);
        while (carve_cmds.size() != 0 || s_tvalid || wall_expect.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_dims(logic [REG_W-1:0] w, logic [REG_W-1:0] h);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= REG_MAZE_WIDTH;
        cfg_wr_data  <= w;
        @(posedge aclk);
        cfg_wr_index <= REG_MAZE_HEIGHT;
        cfg_wr_data  <= h;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        width_reg  = w;
        height_reg = h;
    endtask

    task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                     act_val);
            errors++;
        end
    endtask

    // input side: one beat per accepted command
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                wall_expect.insert(wall_expect.size(),
                                   predict_wall(kind_t'(s_tuser[0]), s_tdata));
            end
            if (send_stretch == 0) begin
                send_stretch = $urandom_range(16, 96);
                send_rough   = $urandom_range(0, 1);
            end else begin
                send_stretch--;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (carve_cmds.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (!no_idle && send_rough && $urandom_range(0, 3) == 0) begin
                    send_gap = $urandom_range(0, 6);
                    s_tvalid <= 1'b0;
                end else begin
                    next_cmd = carve_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_cmd.rnd;
                    s_tuser  <= next_cmd.kind;
                end
            end
        end
    end

    // result side readiness, with one long hold-off to back up the input
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) results_taken++;
            if (!hold_done && results_taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (recv_stretch == 0) begin
                recv_stretch = $urandom_range(16, 96);
                recv_rough   = $urandom_range(0, 1);
            end else begin
                recv_stretch--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else if (!no_idle && recv_rough && $urandom_range(0, 3) == 0) begin
                recv_stall = $urandom_range(0, 6);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (wall_expect.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none, actual %h/%b",
                         $time, m_tdata, m_tuser);
                errors++;
            end else begin
                want = wall_expect.pop_front();
                check_field("wall_x", want.wall_x, m_tdata[5:0]);
                check_field("wall_y", want.wall_y, m_tdata[11:6]);
                check_field("wall_dir", want.wall_dir, m_tdata[13:12]);
                check_field("tdata pad", 0, m_tdata[15:14]);
                check_field("carved", want.carved, m_tuser[0]);
                check_field("finished", want.finished, m_tuser[1]);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        logic [REG_W-1:0] dim_extremes [4];
        logic [REG_W-1:0] w, h;
        int               area, n_steps, sel;
        dim_extremes = '{7'd0, 7'd1, 7'd64, 7'd127};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // step before any start, then a start on the full grid
        queue_cmd(KIND_STEP, 16'h0000);
        queue_cmd(KIND_START, 16'hFFFF);
        queue_cmd(KIND_STEP, 16'h0000);
        queue_cmd(KIND_STEP, 16'hFFFF);
        queue_cmd(KIND_STEP, 16'h0001);
        queue_cmd(KIND_STEP, 16'h0002);
        queue_cmd(KIND_STEP, 16'h8000);
        settle();

        // zero dims act as 1 x 1: last cell pops, then stack already empty
        write_dims(7'd0, 7'd0);
        queue_cmd(KIND_START, 16'h5555);
        queue_cmd(KIND_STEP, 16'hAAAA);
        queue_cmd(KIND_STEP, 16'h1234);
        settle();

        // dims changed mid-maze, shrinking then growing
        write_dims(7'd4, 7'd4);
        queue_cmd(KIND_START, 16'h0000);
        repeat (5) queue_cmd(KIND_STEP, pick_rnd());
        settle();
        write_dims(7'd2, 7'd2);
        repeat (4) queue_cmd(KIND_STEP, pick_rnd());
        settle();
        write_dims(7'd6, 7'd6);
        repeat (4) queue_cmd(KIND_STEP, pick_rnd());
        settle();

        // single row and single column past the limit, walking to the far edge
        write_dims(7'd127, 7'd1);
        queue_cmd(KIND_START, pick_rnd());
        repeat (66) queue_cmd(KIND_STEP, pick_rnd());
        settle();
        write_dims(7'd1, 7'd127);
        queue_cmd(KIND_START, pick_rnd());
        repeat (66) queue_cmd(KIND_STEP, pick_rnd());
        settle();
        write_dims(7'd65, 7'd2);
        queue_cmd(KIND_START, pick_rnd());
        repeat (140) queue_cmd(KIND_STEP, pick_rnd());

        while (items_made < ITEM_TARGET) begin
            settle();
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                w = 7'($urandom_range(0, 127));
                h = 7'($urandom_range(0, 127));
            end else if (sel == 1) begin
                w = dim_extremes[$urandom_range(0, 3)];
                h = dim_extremes[$urandom_range(0, 3)];
            end else begin
                w = 7'($urandom_range(1, 8));
                h = 7'($urandom_range(1, 8));
            end
            write_dims(w, h);
            area = dim_in_use(w, GRID_W) * dim_in_use(h, GRID_H);
            n_steps = (area <= 64) ? area + $urandom_range(1, 4) : $urandom_range(20, 60);
            if ($urandom_range(0, 4) != 0) queue_cmd(KIND_START, pick_rnd());
            repeat (n_steps) begin
                if ($urandom_range(0, 49) == 0) begin
                    queue_cmd(KIND_START, pick_rnd());
                end else begin
                    queue_cmd(KIND_STEP, pick_rnd());
                end
            end
        end

        settle();
        repeat (40) @(posedge aclk);
        if (wall_expect.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, wall_expect.size());
            errors++;
        end
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
